@@ sv/arw_pkg.sv @@
`timescale 1ns / 1ps
// shared constants, codes and types of the resolution weight unit
package arw_pkg;

  localparam int FRAC_BITS   = 16;
  localparam int WEIGHT_BITS = 16;

  localparam int POS_W  = 32;
  localparam int LEN_W  = 31;
  localparam int MODE_W = 2;
  localparam int IDX_W  = 3;
  localparam int OUT_W  = WEIGHT_BITS + 1;
  localparam int H2_W   = LEN_W + 1;
  localparam int SLAB_W = LEN_W + 5;
  localparam int ROOT_W = 32;
  localparam int RAD_W  = 2 * ROOT_W;
  localparam int SREM_W = ROOT_W + 2;
  localparam int Q30_W  = 32;
  localparam int X_W    = 31;
  localparam int PROD_W = 2 * X_W;
  localparam int X_SHIFT = 30 - WEIGHT_BITS;

  localparam int FOLD_STEPS = POS_W;
  localparam int ROOT_STEPS = ROOT_W;
  localparam int DIV_STEPS  = WEIGHT_BITS;
  localparam int POLY_CELLS = 4;
  localparam int SLAB_DLY   = ROOT_STEPS + 2;
  localparam int ZONE_DLY   = DIV_STEPS + 2 + 2 * POLY_CELLS + 3;
  localparam int LATENCY    = 1 + FOLD_STEPS + 4 + ROOT_STEPS + 1 + ZONE_DLY + 1;

  localparam logic [LEN_W-1:0] LEN_ONE = LEN_W'(1) << FRAC_BITS;
  localparam logic [OUT_W-1:0] W_ONE   = OUT_W'(1) << WEIGHT_BITS;

  localparam logic signed [Q30_W-1:0] C9 = 32'sd172272;
  localparam logic signed [Q30_W-1:0] HORNER_COEF [POLY_CELLS] = '{
    -32'sd5026994, 32'sd85569306, -32'sd693598668, 32'sd1686629713
  };

  typedef enum logic [IDX_W-1:0] {
    REG_MODE  = 3'd0,
    REG_BOX_X = 3'd1,
    REG_BOX_Y = 3'd2,
    REG_BOX_Z = 3'd3,
    REG_ATOM  = 3'd4,
    REG_HYB   = 3'd5
  } cfg_reg_e;

  typedef enum logic [MODE_W-1:0] {
    MODE_SLAB   = 2'd0,
    MODE_SPHERE = 2'd1,
    MODE_CYL    = 2'd2
  } geom_e;

  typedef enum logic [1:0] {
    ZONE_ZERO = 2'd0,
    ZONE_ONE  = 2'd1,
    ZONE_RAMP = 2'd2
  } zone_e;

  typedef struct packed {
    zone_e             zone;
    logic [H2_W-1:0]   n;
  } zone_t;

endpackage

@@ sv/adaptive_resolution_weight.sv @@
`timescale 1ns / 1ps
// top level of the resolution weight unit: fold, zone, root, divide and sine chains
// Takes one position per cycle (busy is always low) and gives its weight on
// weight_o with weight_valid_o; results cannot be held off and must be taken in
// that cycle. The latency is set by the 32-cell periodic fold chain, the 32-cell
// square root chain, the 16-cell ramp divide chain and the 4-cell sine
// polynomial. Configuration takes effect for items started after the write;
// write only while no item is in flight.
module adaptive_resolution_weight (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                start,
  output logic                                busy,
  input  logic signed [arw_pkg::POS_W-1:0]    pos_x_i,
  input  logic signed [arw_pkg::POS_W-1:0]    pos_y_i,
  input  logic signed [arw_pkg::POS_W-1:0]    pos_z_i,
  input  logic                                cfg_we_i,
  input  logic [arw_pkg::IDX_W-1:0]           cfg_idx_i,
  input  logic [arw_pkg::LEN_W-1:0]           cfg_data_i,
  output logic                                weight_valid_o,
  output logic [arw_pkg::OUT_W-1:0]           weight_o
);
  localparam int LW = arw_pkg::LEN_W;
  localparam int PW = arw_pkg::POS_W;
  localparam int HW = arw_pkg::H2_W;
  localparam int SW = arw_pkg::SLAB_W;

  // configuration
  logic [arw_pkg::MODE_W-1:0] mode_q;
  logic [LW-1:0]              box_q [3];
  logic [LW-1:0]              atom_q, hyb_q;
  logic [LW-1:0]              len [3];
  logic [LW-1:0]              hyb;
  logic [HW-1:0]              h2;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q   <= arw_pkg::MODE_SLAB;
      box_q[0] <= arw_pkg::LEN_ONE;
      box_q[1] <= arw_pkg::LEN_ONE;
      box_q[2] <= arw_pkg::LEN_ONE;
      atom_q   <= '0;
      hyb_q    <= arw_pkg::LEN_ONE;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        arw_pkg::REG_MODE:  mode_q   <= cfg_data_i[arw_pkg::MODE_W-1:0];
        arw_pkg::REG_BOX_X: box_q[0] <= cfg_data_i;
        arw_pkg::REG_BOX_Y: box_q[1] <= cfg_data_i;
        arw_pkg::REG_BOX_Z: box_q[2] <= cfg_data_i;
        arw_pkg::REG_ATOM:  atom_q   <= cfg_data_i;
        arw_pkg::REG_HYB:   hyb_q    <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_comb begin
    for (int a = 0; a < 3; a++) begin
      len[a] = (box_q[a] == '0) ? LW'(1) : box_q[a];
    end
  end
  assign hyb = (hyb_q == '0) ? LW'(1) : hyb_q;
  assign h2  = {hyb, 1'b0};

  assign busy = 1'b0;

  // valid chain
  logic [arw_pkg::LATENCY-1:0] vld_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[arw_pkg::LATENCY-2:0], start & ~busy};
    end
  end

  // input stage: magnitude and sign
  logic signed [PW-1:0] pos [3];
  logic [PW-1:0]        abs_q [3];
  logic                 neg_q [3];
  assign pos[0] = pos_x_i;
  assign pos[1] = pos_y_i;
  assign pos[2] = pos_z_i;

  always_ff @(posedge clk_i) begin
    for (int a = 0; a < 3; a++) begin
      abs_q[a] <= pos[a][PW-1] ? (~pos[a] + PW'(1)) : pos[a];
      neg_q[a] <= pos[a][PW-1];
    end
  end

  // fold chains
  logic [LW-1:0] frem_w [3][arw_pkg::FOLD_STEPS+1];
  logic [PW-1:0] fdvd_w [3][arw_pkg::FOLD_STEPS+1];
  logic          fneg_w [3][arw_pkg::FOLD_STEPS+1];

  for (genvar a = 0; a < 3; a++) begin : g_axis
    assign frem_w[a][0] = '0;
    assign fdvd_w[a][0] = abs_q[a];
    assign fneg_w[a][0] = neg_q[a];
    for (genvar k = 0; k < arw_pkg::FOLD_STEPS; k++) begin : g_fold
      arw_fold_cell u_cell (
        .clk_i (clk_i),
        .len_i (len[a]),
        .rem_i (frem_w[a][k]),
        .dvd_i (fdvd_w[a][k]),
        .neg_i (fneg_w[a][k]),
        .rem_o (frem_w[a][k+1]),
        .dvd_o (fdvd_w[a][k+1]),
        .neg_o (fneg_w[a][k+1])
      );
    end
  end

  // doubled folded coordinate
  logic [PW-1:0] p_q [3];
  logic [LW-1:0] rem_f [3];
  logic [LW-1:0] r_f [3];
  always_comb begin
    for (int a = 0; a < 3; a++) begin
      rem_f[a] = frem_w[a][arw_pkg::FOLD_STEPS];
      r_f[a]   = (fneg_w[a][arw_pkg::FOLD_STEPS] && rem_f[a] != '0) ?
                 (len[a] - rem_f[a]) : rem_f[a];
    end
  end
  always_ff @(posedge clk_i) begin
    for (int a = 0; a < 3; a++) begin
      p_q[a] <= {r_f[a], 1'b0};
    end
  end

  // slab zone and center offsets
  logic signed [SW-1:0] b1, b2, b3, b4, pxs, nl, nr;
  arw_pkg::zone_t       slab_d;
  arw_pkg::zone_t       slab_dly_q [arw_pkg::SLAB_DLY+1];
  logic [PW:0]          dd [3];
  logic [PW:0]          dm [3];
  logic [LW-1:0]        dmag_q [3];

  assign b1  = SW'(len[0]) - SW'(atom_q) - SW'(h2);
  assign b2  = b1 + SW'(h2);
  assign b3  = b2 + SW'({atom_q, 1'b0});
  assign b4  = b3 + SW'(h2);
  assign pxs = SW'(p_q[0]);
  assign nl  = pxs - b1;
  assign nr  = b4 - pxs;

  always_comb begin
    slab_d.n = '0;
    if (pxs <= b1 || pxs >= b4) begin
      slab_d.zone = arw_pkg::ZONE_ZERO;
    end else if (pxs < b2) begin
      slab_d.zone = arw_pkg::ZONE_RAMP;
      slab_d.n    = nl[HW-1:0];
    end else if (pxs <= b3) begin
      slab_d.zone = arw_pkg::ZONE_ONE;
    end else begin
      slab_d.zone = arw_pkg::ZONE_RAMP;
      slab_d.n    = nr[HW-1:0];
    end
    for (int a = 0; a < 3; a++) begin
      dd[a] = {1'b0, p_q[a]} - (PW+1)'(len[a]);
      dm[a] = dd[a][PW] ? -dd[a] : dd[a];
    end
  end

  always_ff @(posedge clk_i) begin
    slab_dly_q[0] <= slab_d;
    for (int k = 1; k <= arw_pkg::SLAB_DLY; k++) begin
      slab_dly_q[k] <= slab_dly_q[k-1];
    end
    for (int a = 0; a < 3; a++) begin
      dmag_q[a] <= dm[a][LW-1:0];
    end
  end

  // squares and radius squared
  logic [2*LW-1:0]           sq_q [3];
  logic [arw_pkg::RAD_W-1:0] r2_q;
  always_ff @(posedge clk_i) begin
    for (int a = 0; a < 3; a++) begin
      sq_q[a] <= dmag_q[a] * dmag_q[a];
    end
    r2_q <= arw_pkg::RAD_W'(sq_q[0]) + arw_pkg::RAD_W'(sq_q[2]) +
            ((mode_q == arw_pkg::MODE_SPHERE) ? arw_pkg::RAD_W'(sq_q[1])
                                              : arw_pkg::RAD_W'(0));
  end

  // square root chain
  logic [arw_pkg::RAD_W-1:0]  rad_w  [arw_pkg::ROOT_STEPS+1];
  logic [arw_pkg::SREM_W-1:0] srem_w [arw_pkg::ROOT_STEPS+1];
  logic [arw_pkg::ROOT_W-1:0] root_w [arw_pkg::ROOT_STEPS+1];
  assign rad_w[0]  = r2_q;
  assign srem_w[0] = '0;
  assign root_w[0] = '0;
  for (genvar k = 0; k < arw_pkg::ROOT_STEPS; k++) begin : g_root
    arw_sqrt_cell u_cell (
      .clk_i  (clk_i),
      .rad_i  (rad_w[k]),
      .rem_i  (srem_w[k]),
      .root_i (root_w[k]),
      .rad_o  (rad_w[k+1]),
      .rem_o  (srem_w[k+1]),
      .root_o (root_w[k+1])
    );
  end

  // final zone select
  logic [HW+1:0]  rr, a2e, edge_r, nsph;
  arw_pkg::zone_t sph, zone_d;
  arw_pkg::zone_t zone_dly_q [arw_pkg::ZONE_DLY+1];

  assign rr     = (HW+2)'(root_w[arw_pkg::ROOT_STEPS]);
  assign a2e    = (HW+2)'({atom_q, 1'b0});
  assign edge_r = a2e + (HW+2)'(h2);
  assign nsph   = edge_r - rr;

  always_comb begin
    sph.n = nsph[HW-1:0];
    if (rr <= a2e) begin
      sph.zone = arw_pkg::ZONE_ONE;
    end else if (rr < edge_r) begin
      sph.zone = arw_pkg::ZONE_RAMP;
    end else begin
      sph.zone = arw_pkg::ZONE_ZERO;
    end
    zone_d = slab_dly_q[arw_pkg::SLAB_DLY];
    case (mode_q) inside
      arw_pkg::MODE_SLAB: zone_d = slab_dly_q[arw_pkg::SLAB_DLY];
      arw_pkg::MODE_SPHERE, arw_pkg::MODE_CYL: zone_d = sph;
      default: zone_d.zone = arw_pkg::ZONE_ZERO;
    endcase
  end

  always_ff @(posedge clk_i) begin
    zone_dly_q[0] <= zone_d;
    for (int k = 1; k <= arw_pkg::ZONE_DLY; k++) begin
      zone_dly_q[k] <= zone_dly_q[k-1];
    end
  end

  // ramp divide chain
  logic [HW-1:0]                   drem_w [arw_pkg::DIV_STEPS+1];
  logic [arw_pkg::WEIGHT_BITS-1:0] quo_w  [arw_pkg::DIV_STEPS+1];
  assign drem_w[0] = zone_dly_q[0].n;
  assign quo_w[0]  = '0;
  for (genvar k = 0; k < arw_pkg::DIV_STEPS; k++) begin : g_div
    arw_div_cell u_cell (
      .clk_i (clk_i),
      .den_i (h2),
      .rem_i (drem_w[k]),
      .quo_i (quo_w[k]),
      .rem_o (drem_w[k+1]),
      .quo_o (quo_w[k+1])
    );
  end

  // sine argument and its square
  logic [arw_pkg::X_W-1:0]    x_d, x_q, x2_q;
  logic [arw_pkg::PROD_W-1:0] xx;
  assign x_d = {1'b0, quo_w[arw_pkg::DIV_STEPS], {arw_pkg::X_SHIFT{1'b0}}};
  assign xx  = x_q * x_q;
  always_ff @(posedge clk_i) begin
    x_q  <= x_d;
    x2_q <= xx[30 +: arw_pkg::X_W];
  end

  logic [arw_pkg::X_W-1:0]           xd_q;
  always_ff @(posedge clk_i) begin
    xd_q <= x_q;
  end

  // horner chain
  logic signed [arw_pkg::Q30_W-1:0] pp_w  [arw_pkg::POLY_CELLS+1];
  logic [arw_pkg::X_W-1:0]          px2_w [arw_pkg::POLY_CELLS+1];
  logic [arw_pkg::X_W-1:0]          pxx_w [arw_pkg::POLY_CELLS+1];
  assign pp_w[0]  = arw_pkg::C9;
  assign px2_w[0] = x2_q;
  assign pxx_w[0] = xd_q;
  for (genvar k = 0; k < arw_pkg::POLY_CELLS; k++) begin : g_poly
    arw_poly_cell u_cell (
      .clk_i  (clk_i),
      .coef_i (arw_pkg::HORNER_COEF[k]),
      .p_i    (pp_w[k]),
      .x2_i   (px2_w[k]),
      .x_i    (pxx_w[k]),
      .p_o    (pp_w[k+1]),
      .x2_o   (px2_w[k+1]),
      .x_o    (pxx_w[k+1])
    );
  end

  // sine, square, rounding
  logic signed [arw_pkg::Q30_W-1:0] pf;
  logic [arw_pkg::Q30_W-1:0]        pmag;
  logic [arw_pkg::PROD_W-1:0]       sp_q, s2_q;
  logic                             ssgn_q;
  logic [arw_pkg::X_W-1:0]          s_q;
  logic [arw_pkg::PROD_W:0]         wr;
  logic [arw_pkg::PROD_W-60+arw_pkg::WEIGHT_BITS:0] wv;
  logic [arw_pkg::OUT_W-1:0]        wcap, weight_d, weight_q;
  arw_pkg::zone_t                   zfin;

  assign pf   = pp_w[arw_pkg::POLY_CELLS];
  assign pmag = pf[arw_pkg::Q30_W-1] ? -pf : pf;
  assign wr   = (arw_pkg::PROD_W+1)'(s2_q) +
                ((arw_pkg::PROD_W+1)'(1) << (59 - arw_pkg::WEIGHT_BITS));
  assign wv   = wr[arw_pkg::PROD_W:60-arw_pkg::WEIGHT_BITS];
  assign wcap = (wv > $bits(wv)'(arw_pkg::W_ONE)) ? arw_pkg::W_ONE
                                                  : wv[arw_pkg::OUT_W-1:0];
  assign zfin = zone_dly_q[arw_pkg::ZONE_DLY];

  always_comb begin
    case (zfin.zone)
      arw_pkg::ZONE_ONE:  weight_d = arw_pkg::W_ONE;
      arw_pkg::ZONE_RAMP: weight_d = wcap;
      default:            weight_d = '0;
    endcase
  end

  always_ff @(posedge clk_i) begin
    sp_q     <= pmag[arw_pkg::X_W-1:0] * pxx_w[arw_pkg::POLY_CELLS];
    ssgn_q   <= pf[arw_pkg::Q30_W-1];
    s_q      <= ssgn_q ? '0 : sp_q[30 +: arw_pkg::X_W];
    s2_q     <= s_q * s_q;
    weight_q <= weight_d;
  end

  assign weight_valid_o = vld_q[arw_pkg::LATENCY-1];
  assign weight_o       = weight_q;
endmodule

@@ sv/arw_fold_cell.sv @@
`timescale 1ns / 1ps
// one restoring remainder step of the periodic fold
module arw_fold_cell (
  input  logic                       clk_i,
  input  logic [arw_pkg::LEN_W-1:0]  len_i,
  input  logic [arw_pkg::LEN_W-1:0]  rem_i,
  input  logic [arw_pkg::POS_W-1:0]  dvd_i,
  input  logic                       neg_i,
  output logic [arw_pkg::LEN_W-1:0]  rem_o,
  output logic [arw_pkg::POS_W-1:0]  dvd_o,
  output logic                       neg_o
);
  logic [arw_pkg::LEN_W:0]   trial;
  logic [arw_pkg::LEN_W:0]   diff;
  logic [arw_pkg::LEN_W-1:0] rem_d, rem_q;
  logic [arw_pkg::POS_W-1:0] dvd_q;
  logic                      neg_q;

  assign trial = {rem_i, dvd_i[arw_pkg::POS_W-1]};
  assign diff  = trial - {1'b0, len_i};
  assign rem_d = (trial >= {1'b0, len_i}) ? diff[arw_pkg::LEN_W-1:0]
                                          : trial[arw_pkg::LEN_W-1:0];

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    dvd_q <= {dvd_i[arw_pkg::POS_W-2:0], 1'b0};
    neg_q <= neg_i;
  end

  assign rem_o = rem_q;
  assign dvd_o = dvd_q;
  assign neg_o = neg_q;
endmodule

@@ sv/arw_sqrt_cell.sv @@
`timescale 1ns / 1ps
// one digit step of the integer square root
module arw_sqrt_cell (
  input  logic                        clk_i,
  input  logic [arw_pkg::RAD_W-1:0]   rad_i,
  input  logic [arw_pkg::SREM_W-1:0]  rem_i,
  input  logic [arw_pkg::ROOT_W-1:0]  root_i,
  output logic [arw_pkg::RAD_W-1:0]   rad_o,
  output logic [arw_pkg::SREM_W-1:0]  rem_o,
  output logic [arw_pkg::ROOT_W-1:0]  root_o
);
  logic [arw_pkg::SREM_W+1:0] t, trial, diff;
  logic                       ge;
  logic [arw_pkg::SREM_W-1:0] rem_q;
  logic [arw_pkg::ROOT_W-1:0] root_q;
  logic [arw_pkg::RAD_W-1:0]  rad_q;

  assign t     = {rem_i, rad_i[arw_pkg::RAD_W-1 -: 2]};
  assign trial = {2'b00, root_i, 2'b01};
  assign ge    = (t >= trial);
  assign diff  = t - trial;

  always_ff @(posedge clk_i) begin
    rem_q  <= ge ? diff[arw_pkg::SREM_W-1:0] : t[arw_pkg::SREM_W-1:0];
    root_q <= {root_i[arw_pkg::ROOT_W-2:0], ge};
    rad_q  <= {rad_i[arw_pkg::RAD_W-3:0], 2'b00};
  end

  assign rem_o  = rem_q;
  assign root_o = root_q;
  assign rad_o  = rad_q;
endmodule

@@ sv/arw_div_cell.sv @@
`timescale 1ns / 1ps
// one quotient bit of the ramp position divide
module arw_div_cell (
  input  logic                            clk_i,
  input  logic [arw_pkg::H2_W-1:0]        den_i,
  input  logic [arw_pkg::H2_W-1:0]        rem_i,
  input  logic [arw_pkg::WEIGHT_BITS-1:0] quo_i,
  output logic [arw_pkg::H2_W-1:0]        rem_o,
  output logic [arw_pkg::WEIGHT_BITS-1:0] quo_o
);
  logic [arw_pkg::H2_W:0]          t, diff;
  logic                            ge;
  logic [arw_pkg::H2_W-1:0]        rem_q;
  logic [arw_pkg::WEIGHT_BITS-1:0] quo_q;

  assign t    = {rem_i, 1'b0};
  assign ge   = (t >= {1'b0, den_i});
  assign diff = t - {1'b0, den_i};

  always_ff @(posedge clk_i) begin
    rem_q <= ge ? diff[arw_pkg::H2_W-1:0] : t[arw_pkg::H2_W-1:0];
    quo_q <= {quo_i[arw_pkg::WEIGHT_BITS-2:0], ge};
  end

  assign rem_o = rem_q;
  assign quo_o = quo_q;
endmodule

@@ sv/arw_poly_cell.sv @@
`timescale 1ns / 1ps
// one horner step of the sine polynomial, multiply then add
module arw_poly_cell (
  input  logic                               clk_i,
  input  logic signed [arw_pkg::Q30_W-1:0]   coef_i,
  input  logic signed [arw_pkg::Q30_W-1:0]   p_i,
  input  logic [arw_pkg::X_W-1:0]            x2_i,
  input  logic [arw_pkg::X_W-1:0]            x_i,
  output logic signed [arw_pkg::Q30_W-1:0]   p_o,
  output logic [arw_pkg::X_W-1:0]            x2_o,
  output logic [arw_pkg::X_W-1:0]            x_o
);
  logic [arw_pkg::Q30_W-1:0]         mag;
  logic [arw_pkg::PROD_W-1:0]        prod_q;
  logic                              sgn_q;
  logic [arw_pkg::X_W-1:0]           x2a_q, xa_q, x2b_q, xb_q;
  logic [arw_pkg::Q30_W-1:0]         sh, term;
  logic signed [arw_pkg::Q30_W-1:0]  p_q;

  assign mag  = p_i[arw_pkg::Q30_W-1] ? -p_i : p_i;
  assign sh   = prod_q[arw_pkg::PROD_W-1:30];
  assign term = sgn_q ? -sh : sh;

  always_ff @(posedge clk_i) begin
    prod_q <= mag[arw_pkg::X_W-1:0] * x2_i;
    sgn_q  <= p_i[arw_pkg::Q30_W-1];
    x2a_q  <= x2_i;
    xa_q   <= x_i;
    p_q    <= coef_i + $signed(term);
    x2b_q  <= x2a_q;
    xb_q   <= xa_q;
  end

  assign p_o  = p_q;
  assign x2_o = x2b_q;
  assign x_o  = xb_q;
endmodule

@@ sv/arw_checker.sv @@
`timescale 1ns / 1ps
// port checker of the resolution weight unit and its bind
module arw_checker (
  input logic                             clk_i,
  input logic                             rst_ni,
  input logic                             start,
  input logic                             busy,
  input logic                             weight_valid_o,
  input logic [arw_pkg::OUT_W-1:0]        weight_o
);
  a_never_busy: assert property (@(posedge clk_i) disable iff (!rst_ni) !busy)
    else $error("busy raised");

  a_weight_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    weight_valid_o |-> weight_o <= arw_pkg::W_ONE)
    else $error("weight above one");

  a_result_has_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    weight_valid_o |-> $past(start && !busy, arw_pkg::LATENCY))
    else $error("result without item");

  a_reset_clears: assert property (@(posedge clk_i)
    $past(!rst_ni) |-> !weight_valid_o)
    else $error("result after reset");
endmodule

bind adaptive_resolution_weight arw_checker u_arw_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .start          (start),
  .busy           (busy),
  .weight_valid_o (weight_valid_o),
  .weight_o       (weight_o)
);

@@ verif/tb_adaptive_resolution_weight.sv @@
`timescale 1ns / 1ps
// self-checking testbench of the resolution weight unit: random and directed positions
module tb_adaptive_resolution_weight;
  import arw_pkg::*;

  typedef struct {
    logic signed [31:0] px;
    logic signed [31:0] py;
    logic signed [31:0] pz;
  } pos_item_t;

  localparam longint Q_C1 = 1686629713;
  localparam longint Q_C3 = -693598668;
  localparam longint Q_C5 = 85569306;
  localparam longint Q_C7 = -5026994;
  localparam longint Q_C9 = 172272;
  localparam int CYCLE_LIMIT = 400000;

  logic clk_i = 0;
  logic rst_ni = 0;
  logic start = 0;
  logic busy;
  logic signed [31:0] pos_x_i = 0, pos_y_i = 0, pos_z_i = 0;
  logic cfg_we_i = 0;
  logic [IDX_W-1:0] cfg_idx_i = REG_MODE;
  logic [LEN_W-1:0] cfg_data_i = 0;
  logic weight_valid_o;
  logic [OUT_W-1:0] weight_o;

  pos_item_t pending_items[$];
  logic [OUT_W-1:0] expected_weights[$];
  int gap_left = 0;
  int errors = 0;
  int cycles = 0;

  // model copy of the registers
  logic [1:0] m_mode;
  longint m_lx, m_ly, m_lz, m_atom, m_hyb;

  adaptive_resolution_weight DUT (.*);

  always #4 clk_i = ~clk_i;

  function automatic longint q30_mul(longint a, longint b);
    logic neg;
    longint ua, ub, p;
    neg = (a < 0) != (b < 0);
    ua = a < 0 ? -a : a;
    ub = b < 0 ? -b : b;
    p = (ua * ub) >>> 30;
    return neg ? -p : p;
  endfunction

  function automatic longint sin_squared(longint u);
    longint x, x2, p, s, w;
    logic [63:0] s2;
    if (u > 65536) u = 65536;
    x = u <<< (30 - WEIGHT_BITS);
    x2 = q30_mul(x, x);
    p = Q_C9;
    p = Q_C7 + q30_mul(p, x2);
    p = Q_C5 + q30_mul(p, x2);
    p = Q_C3 + q30_mul(p, x2);
    p = Q_C1 + q30_mul(p, x2);
    s = q30_mul(p, x);
    if (s < 0) s = 0;
    s2 = s * s;
    w = longint'((s2 + (64'd1 << (59 - WEIGHT_BITS))) >> (60 - WEIGHT_BITS));
    return w > 65536 ? 65536 : w;
  endfunction

  function automatic longint ramp_weight(longint n, longint den);
    if (n <= 0) return 0;
    if (n >= den) return 65536;
    return sin_squared((n <<< WEIGHT_BITS) / den);
  endfunction

  function automatic longint fold_doubled(logic signed [31:0] raw, longint len);
    longint v, r;
    v = raw;
    r = v % len;
    if (r < 0) r += len;
    return 2 * r;
  endfunction

  function automatic longint isqrt(logic [63:0] v);
    logic [63:0] res, bt;
    res = 0;
    bt = 64'd1 << 62;
    while (bt > v) bt >>= 2;
    while (bt != 0) begin
      if (v >= res + bt) begin
        v -= res + bt;
        res = (res >> 1) + bt;
      end else begin
        res >>= 1;
      end
      bt >>= 2;
    end
    return longint'(res);
  endfunction

  function automatic logic [OUT_W-1:0] predict_weight(pos_item_t it);
    longint lx, ly, lz, a2, h2, px, py, pz, b1, b2, b3, b4, dx, dy, dz, r, w;
    logic [63:0] r2;
    lx = m_lx == 0 ? 1 : m_lx;
    ly = m_ly == 0 ? 1 : m_ly;
    lz = m_lz == 0 ? 1 : m_lz;
    a2 = 2 * m_atom;
    h2 = 2 * (m_hyb == 0 ? 1 : m_hyb);
    px = fold_doubled(it.px, lx);
    py = fold_doubled(it.py, ly);
    pz = fold_doubled(it.pz, lz);
    w = 0;
    if (m_mode == MODE_SLAB) begin
      b1 = lx - a2 / 2 - h2;
      b2 = b1 + h2;
      b3 = b2 + a2;
      b4 = b3 + h2;
      if (px <= b1 || px >= b4) w = 0;
      else if (px < b2) w = ramp_weight(px - b1, h2);
      else if (px <= b3) w = 65536;
      else w = ramp_weight(b4 - px, h2);
    end else if (m_mode == MODE_SPHERE || m_mode == MODE_CYL) begin
      dx = px - lx;
      dy = py - ly;
      dz = pz - lz;
      r2 = dx * dx + dz * dz;
      if (m_mode == MODE_SPHERE) r2 += dy * dy;
      r = isqrt(r2);
      if (r <= a2) w = 65536;
      else if (r < a2 + h2) w = ramp_weight(a2 + h2 - r, h2);
    end
    return OUT_W'(w);
  endfunction

  function automatic int pick_gap();
    int k;
    k = $urandom_range(0, 99);
    if (k < 60) return 0;
    if (k < 95) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // driver
  always @(posedge clk_i) begin
    if (start && !busy) begin
      expected_weights.push_back(predict_weight('{pos_x_i, pos_y_i, pos_z_i}));
    end
    if (!rst_ni) begin
      start <= 0;
    end else if (gap_left > 0) begin
      gap_left <= gap_left - 1;
      start <= 0;
    end else if (pending_items.size() > 0 && !(start && busy)) begin
      pos_item_t it;
      it = pending_items.pop_front();
      pos_x_i <= it.px;
      pos_y_i <= it.py;
      pos_z_i <= it.pz;
      start <= 1;
      gap_left <= pick_gap();
    end else if (!(start && busy)) begin
      start <= 0;
    end
  end

  // monitor
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (rst_ni && weight_valid_o) begin
      if (expected_weights.size() == 0) begin
        $error("weight: unexpected result %0d", weight_o);
        errors <= errors + 1;
      end else begin
        logic [OUT_W-1:0] e;
        e = expected_weights.pop_front();
        if (e !== weight_o) begin
          $error("weight: expected %0d actual %0d", e, weight_o);
          errors <= errors + 1;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (cycles > CYCLE_LIMIT) begin
      $display("adaptive_resolution_weight regression: fail");
      $finish;
    end
  end

  task automatic write_reg(cfg_reg_e idx, logic [LEN_W-1:0] val);
    @(posedge clk_i);
    cfg_we_i <= 1;
    cfg_idx_i <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 0;
    case (idx)
      REG_MODE: m_mode = val[1:0];
      REG_BOX_X: m_lx = val;
      REG_BOX_Y: m_ly = val;
      REG_BOX_Z: m_lz = val;
      REG_ATOM: m_atom = val;
      REG_HYB: m_hyb = val;
      default: ;
    endcase
  endtask

  task automatic drain();
    while (pending_items.size() > 0 || start || expected_weights.size() > 0)
      @(posedge clk_i);
    repeat (LATENCY + 5) @(posedge clk_i);
  endtask

  function automatic logic signed [31:0] rand_pos(longint len);
    int k;
    k = $urandom_range(0, 9);
    if (k < 2) return $urandom;
    if (k < 3) return k[0] ? 32'sh7fffffff : 32'sh80000000;
    return 32'($urandom_range(0, 32'(len > 0 ? len - 1 : 0)))
           + (k == 9 ? 32'(len) * $signed($urandom_range(0, 6) - 3) : 0);
  endfunction

  task automatic add_item(logic signed [31:0] x, logic signed [31:0] y,
                          logic signed [31:0] z);
    pending_items.push_back('{x, y, z});
  endtask

  task automatic random_phase(int count);
    repeat (count) add_item(rand_pos(m_lx), rand_pos(m_ly), rand_pos(m_lz));
    drain();
  endtask

  initial begin
    m_mode = MODE_SLAB;
    m_lx = 65536; m_ly = 65536; m_lz = 65536;
    m_atom = 0; m_hyb = 65536;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1;

    // directed: reset settings, extremes and boundaries
    add_item(0, 0, 0);
    add_item(32'sh7fffffff, 32'sh80000000, -1);
    add_item(32'sh80000000, 32'sh7fffffff, 1);
    add_item(32768, 32768, 32768);
    drain();
    write_reg(REG_BOX_X, 400);
    write_reg(REG_ATOM, 40);
    write_reg(REG_HYB, 60);
    // slab boundaries: b1=240 b2=360 b3=440 b4=560 (doubled)
    add_item(60, 0, 0); add_item(61, 0, 0); add_item(120, 0, 0);
    add_item(160, 0, 0); add_item(161, 0, 0); add_item(219, 0, 0);
    add_item(220, 0, 0); add_item(-1, 0, 0); add_item(400, 0, 0);
    add_item(180, 0, 0); add_item(279, 0, 0); add_item(280, 0, 0);
    drain();
    write_reg(REG_ATOM, 500);         // oversized atomistic zone
    add_item(0, 0, 0); add_item(200, 0, 0); add_item(399, 0, 0);
    drain();
    write_reg(REG_MODE, 2'd3);        // unused mode
    add_item(10, 10, 10);
    drain();
    write_reg(REG_BOX_X, 0);          // zero lengths
    write_reg(REG_BOX_Y, 0);
    write_reg(REG_BOX_Z, 0);
    write_reg(REG_HYB, 0);
    write_reg(REG_MODE, MODE_SPHERE);
    write_reg(REG_ATOM, 0);
    add_item(5, -5, 32'sh7fffffff);
    drain();
    write_reg(REG_MODE, MODE_SLAB);
    add_item(1, 2, 3);
    drain();

    // random phases over several settings
    write_reg(REG_MODE, MODE_SLAB);
    write_reg(REG_BOX_X, 31'h40000); write_reg(REG_ATOM, 31'h8000);
    write_reg(REG_HYB, 31'h10000);
    random_phase(150);
    write_reg(REG_MODE, MODE_SPHERE);
    write_reg(REG_BOX_Y, 31'h40000); write_reg(REG_BOX_Z, 31'h40000);
    write_reg(REG_ATOM, 31'h8000); write_reg(REG_HYB, 31'h8000);
    random_phase(150);
    write_reg(REG_MODE, MODE_CYL);
    random_phase(150);
    write_reg(REG_BOX_X, 31'h7fffffff); write_reg(REG_BOX_Y, 31'h7fffffff);
    write_reg(REG_BOX_Z, 31'h7fffffff); write_reg(REG_ATOM, 31'h7fffffff);
    write_reg(REG_HYB, 31'h7fffffff);
    write_reg(REG_MODE, MODE_SPHERE);
    random_phase(100);
    write_reg(REG_MODE, MODE_SLAB);
    write_reg(REG_ATOM, 31'h10000000); write_reg(REG_HYB, 31'h20000000);
    random_phase(100);
    repeat (3) begin
      write_reg(REG_MODE, 2'($urandom_range(0, 2)));
      write_reg(REG_BOX_X, 31'($urandom_range(1, 32'h7fffffff)));
      write_reg(REG_BOX_Y, 31'($urandom_range(1, 32'h7fffffff)));
      write_reg(REG_BOX_Z, 31'($urandom_range(1, 32'h7fffffff)));
      write_reg(REG_ATOM, 31'($urandom_range(0, 32'h3fffffff)));
      write_reg(REG_HYB, 31'($urandom_range(1, 32'h3fffffff)));
      random_phase(85);
    end

    if (errors == 0) $display("adaptive_resolution_weight regression: pass");
    else $display("adaptive_resolution_weight regression: fail");
    $finish;
  end

endmodule
